[sv/lbdr_pkg.sv]
// Shared types and constants for the LED boost dead-band regulator.
// Used by lbdr_divider, lbdr_scale and the top level; depends on nothing.
package lbdr_pkg;

   // Converter sample width and the full-scale shift of the LED reading.
   localparam int SAMPLE_W = 12;
   localparam int ADC_BITS = 12;

   // Millivolt fields and duty width.
   localparam int MV_W   = 16;
   localparam int DUTY_W = 8;
   localparam int ACT_W  = 2;

   // Supply scale: 2.495 V reference times full scale, as a dividend.
   localparam int DIV_W     = 24;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam logic [DIV_W-1:0] SUPPLY_SCALE = 24'd10215000;

   // Product of supply, sample and divider gain before the shift.
   localparam int PROD_W = MV_W + SAMPLE_W;
   localparam int WIDE_W = PROD_W + 4;
   localparam logic [3:0] DIVIDER_GAIN = 4'd11;

   localparam logic [MV_W-1:0] SAT16 = {MV_W{1'b1}};

   // Configuration register indexes.
   localparam logic [1:0] REG_TARGET  = 2'd0;
   localparam logic [1:0] REG_BAND    = 2'd1;
   localparam logic [1:0] REG_CEILING = 2'd2;

   // Reset values of the registers and of the duty state.
   localparam logic [MV_W-1:0]   TARGET_RESET  = 16'd8000;
   localparam logic [MV_W-1:0]   BAND_RESET    = 16'd1000;
   localparam logic [DUTY_W-1:0] CEILING_RESET = 8'd24;
   localparam logic [DUTY_W-1:0] DUTY_RESET    = 8'd1;
   localparam logic [DUTY_W-1:0] DUTY_FLOOR    = 8'd1;

   // Regulation action codes.
   localparam logic [ACT_W-1:0] ACT_HOLD = 2'd0;
   localparam logic [ACT_W-1:0] ACT_UP   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DOWN = 2'd2;

   // Divider control and status.
   typedef struct packed {
      logic                start;
      logic [SAMPLE_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_stat_type;

   // Scaling unit control and status.
   typedef struct packed {
      logic                start;
      logic [MV_W-1:0]     supply;
      logic [SAMPLE_W-1:0] sample;
   } scale_ctrl_type;

   typedef struct packed {
      logic            done;
      logic [MV_W-1:0] led_mv;
   } scale_stat_type;

endpackage

[sv/led_boost_deadband_regulator_unit.sv]
// Top level of the LED boost dead-band regulator: sequencer, configuration
// registers, duty state and result register. Uses lbdr_pkg, lbdr_divider, lbdr_scale.
//
//   channel  dir  width  content
//   req      in   24     ref_sample [11:0], led_sample [23:12]
//   rsp      out  32     duty [7:0], led_mv [23:8], action [25:24], zero fill
//   csr      in   2+16   register index, write data
//
// A sample pair's result is loaded after the divider steps, the load of the
// saturated supply, the two scaling stages, the load of the LED voltage and
// the regulation step. The next pair is taken right after the result is loaded,
// even if it waits, so a new pair is never taken before the last result is loaded.
// Reset is synchronous and restores the register defaults and a duty of one.
// A result that is ready while the previous one still waits holds the sequencer
// in its step state until that beat leaves.
module led_boost_deadband_regulator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // ref_sample [11:0], led_sample [23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // duty [7:0], led_mv [23:8], action [25:24]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_SAT   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_STEP  = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [lbdr_pkg::MV_W-1:0]          target_ff, target_in;
   logic [lbdr_pkg::MV_W-1:0]          band_ff, band_in;
   logic [lbdr_pkg::DUTY_W-1:0]        ceiling_ff, ceiling_in;
   logic [lbdr_pkg::DUTY_W-1:0]        duty_ff, duty_in;
   logic [lbdr_pkg::SAMPLE_W-1:0]      led_ff, led_in;
   logic [lbdr_pkg::MV_W-1:0]          supply_ff, supply_in;
   logic [lbdr_pkg::MV_W-1:0]          mv_ff, mv_in;
   logic                               rsp_vld_ff, rsp_vld_in;
   logic [31:0]                        rsp_data_ff, rsp_data_in;
   logic                               req_beat;
   logic                               out_free;
   logic [lbdr_pkg::MV_W:0]            mv_plus_band;
   logic [lbdr_pkg::MV_W:0]            high_bound;
   logic                               below;
   logic                               above;
   logic [lbdr_pkg::ACT_W-1:0]         action;
   logic [lbdr_pkg::DUTY_W-1:0]        duty_next;
   lbdr_pkg::div_ctrl_type             div_ctrl;
   lbdr_pkg::div_stat_type             div_stat;
   lbdr_pkg::scale_ctrl_type           scale_ctrl;
   lbdr_pkg::scale_stat_type           scale_stat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   // Shared units.
   assign div_ctrl.start   = req_beat;
   assign div_ctrl.divisor = req_tdata[lbdr_pkg::SAMPLE_W-1:0];

   lbdr_divider u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   assign scale_ctrl.start  = (state_ff == ST_SAT);
   assign scale_ctrl.supply = supply_ff;
   assign scale_ctrl.sample = led_ff;

   lbdr_scale u_scale (
      .clock (clock),
      .reset (reset),
      .ctrl  (scale_ctrl),
      .stat  (scale_stat)
   );

   // Dead-band compare at 17 bits: a band wider than the target never trips low.
   assign mv_plus_band = {1'b0, mv_ff} + {1'b0, band_ff};
   assign high_bound   = {1'b0, target_ff} + {1'b0, band_ff};
   assign below        = mv_plus_band < {1'b0, target_ff};
   assign above        = {1'b0, mv_ff} > high_bound;

   // One regulation step on the duty value.
   always_comb begin
      action    = lbdr_pkg::ACT_HOLD;
      duty_next = duty_ff;
      if (below) begin
         action = lbdr_pkg::ACT_UP;
         if (duty_ff < ceiling_ff) begin
            duty_next = duty_ff + 1'b1;
         end
      end else if (above) begin
         action = lbdr_pkg::ACT_DOWN;
         if (duty_ff > lbdr_pkg::DUTY_FLOOR) begin
            duty_next = duty_ff - 1'b1;
         end
      end
   end

   // Sequencer and datapath registers.
   always_comb begin
      state_in    = state_ff;
      led_in      = led_ff;
      supply_in   = supply_ff;
      mv_in       = mv_ff;
      duty_in     = duty_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               led_in   = req_tdata[2*lbdr_pkg::SAMPLE_W-1:lbdr_pkg::SAMPLE_W];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               supply_in = (div_stat.quotient[lbdr_pkg::DIV_W-1:lbdr_pkg::MV_W] != '0)
                           ? lbdr_pkg::SAT16
                           : div_stat.quotient[lbdr_pkg::MV_W-1:0];
               state_in  = ST_SAT;
            end
         end
         ST_SAT: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (scale_stat.done) begin
               mv_in    = scale_stat.led_mv;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (out_free) begin
               duty_in     = duty_next;
               rsp_vld_in  = 1'b1;
               rsp_data_in = {6'd0, action, mv_ff, duty_next};
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes; indexes past the list are dropped.
   always_comb begin
      target_in  = target_ff;
      band_in    = band_ff;
      ceiling_in = ceiling_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lbdr_pkg::REG_TARGET:  target_in  = csr_data;
            lbdr_pkg::REG_BAND:    band_in    = csr_data;
            lbdr_pkg::REG_CEILING: ceiling_in = csr_data[lbdr_pkg::DUTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         target_ff  <= lbdr_pkg::TARGET_RESET;
         band_ff    <= lbdr_pkg::BAND_RESET;
         ceiling_ff <= lbdr_pkg::CEILING_RESET;
         duty_ff    <= lbdr_pkg::DUTY_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         target_ff  <= target_in;
         band_ff    <= band_in;
         ceiling_ff <= ceiling_in;
         duty_ff    <= duty_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      led_ff      <= led_in;
      supply_ff   <= supply_in;
      mv_ff       <= mv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sv/lbdr_divider.sv]
// Restoring divider: constant supply scale over the reference sample,
// one quotient bit per cycle. Depends on lbdr_pkg.
module lbdr_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  lbdr_pkg::div_ctrl_type ctrl,
   output lbdr_pkg::div_stat_type stat
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [lbdr_pkg::DIV_CNT_W-1:0]    step_ff, step_in;
   logic [lbdr_pkg::DIV_W-1:0]        quo_ff, quo_in;
   logic [lbdr_pkg::SAMPLE_W-1:0]     rem_ff, rem_in;
   logic [lbdr_pkg::SAMPLE_W-1:0]     dvs_ff, dvs_in;
   logic [lbdr_pkg::SAMPLE_W:0]       rem_shift;
   logic                              fits;

   // One step: shift the next dividend bit into the remainder and try a subtract.
   // A zero divisor always fits, so the quotient comes out all ones and saturates.
   assign rem_shift = {rem_ff, quo_ff[lbdr_pkg::DIV_W-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (ctrl.start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = lbdr_pkg::DIV_CNT_W'(lbdr_pkg::DIV_W - 1);
         quo_in  = lbdr_pkg::SUPPLY_SCALE;
         rem_in  = '0;
         dvs_in  = ctrl.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[lbdr_pkg::DIV_W-2:0], fits};
         rem_in = fits ? lbdr_pkg::SAMPLE_W'(rem_shift - {1'b0, dvs_ff})
                       : rem_shift[lbdr_pkg::SAMPLE_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

[sv/lbdr_scale.sv]
// Two-stage scaling unit: supply times LED sample, then times the divider
// gain, shifted down by the converter width and saturated. Depends on lbdr_pkg.
module lbdr_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  lbdr_pkg::scale_ctrl_type ctrl,
   output lbdr_pkg::scale_stat_type stat
);

   logic                               mul_vld_ff;
   logic                               done_ff;
   logic [lbdr_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [lbdr_pkg::MV_W-1:0]          mv_ff, mv_in;
   logic [lbdr_pkg::WIDE_W-1:0]        gained;
   logic [lbdr_pkg::WIDE_W-1:0]        shifted;

   // First stage: the one real multiplier, 16 by 12 bits.
   assign prod_in = lbdr_pkg::PROD_W'(ctrl.supply) * lbdr_pkg::PROD_W'(ctrl.sample);

   // Second stage: constant gain, full-scale shift and saturation.
   assign gained  = lbdr_pkg::WIDE_W'(prod_ff) * lbdr_pkg::WIDE_W'(lbdr_pkg::DIVIDER_GAIN);
   assign shifted = gained >> lbdr_pkg::ADC_BITS;
   assign mv_in   = (shifted > lbdr_pkg::WIDE_W'(lbdr_pkg::SAT16))
                    ? lbdr_pkg::SAT16 : shifted[lbdr_pkg::MV_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         mul_vld_ff <= ctrl.start;
         done_ff    <= mul_vld_ff;
      end
      prod_ff <= prod_in;
      mv_ff   <= mv_in;
   end

   assign stat.done   = done_ff;
   assign stat.led_mv = mv_ff;

endmodule

[sim/lbdr_regulation_checker.sv]
// Checker for the LED boost dead-band regulator: watches the sample, result and
// register channels, predicts every result beat and compares it with the block.
// Depends on lbdr_pkg for field widths, register indexes and action codes.
module lbdr_regulation_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // ref_sample [11:0], led_sample [23:12]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // duty [7:0], led_mv [23:8], action [25:24]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          mismatch_count,
   output int          outstanding,
   output int          results_checked
);

   // Full-scale reference product and divider gain of the LED sense path.
   localparam int unsigned VREF_SCALE = 10215000;
   localparam int unsigned SENSE_GAIN = 11;
   localparam int          REPORT_MAX = 10;

   typedef struct packed {
      logic [lbdr_pkg::DUTY_W-1:0] duty;
      logic [lbdr_pkg::MV_W-1:0]   led_mv;
      logic [lbdr_pkg::ACT_W-1:0]  action;
   } regulation_type;

   // Shadow copy of the registers and of the duty state.
   logic [lbdr_pkg::MV_W-1:0]   target_shadow;
   logic [lbdr_pkg::MV_W-1:0]   band_shadow;
   logic [lbdr_pkg::DUTY_W-1:0] ceiling_shadow;
   logic [lbdr_pkg::DUTY_W-1:0] duty_shadow;

   regulation_type pending_results[$];
   int             errors;
   int             checked;

   // One regulation step: supply from the reference reading, LED voltage from
   // the divided reading, then a single duty step against the dead band.
   function automatic regulation_type regulate_pair(
      input logic [lbdr_pkg::SAMPLE_W-1:0] ref_code,
      input logic [lbdr_pkg::SAMPLE_W-1:0] led_code,
      input logic [lbdr_pkg::MV_W-1:0]     target,
      input logic [lbdr_pkg::MV_W-1:0]     band,
      input logic [lbdr_pkg::DUTY_W-1:0]   ceiling,
      input logic [lbdr_pkg::DUTY_W-1:0]   duty_now
   );
      regulation_type res;
      logic [31:0]    supply;
      logic [47:0]    scaled;
      int             low_bound;
      int             high_bound;
      int             level;
      int             t_mv;
      int             b_mv;

      // A zero reading would divide by zero; it saturates like a large quotient.
      if (ref_code == '0) begin
         supply = 32'd65535;
      end else begin
         supply = VREF_SCALE / 32'(ref_code);
         if (supply > 32'd65535) begin
            supply = 32'd65535;
         end
      end

      scaled = (48'(supply) * 48'(led_code) * 48'(SENSE_GAIN)) >> lbdr_pkg::ADC_BITS;
      res.led_mv = (scaled > 48'd65535) ? 16'hFFFF : scaled[15:0];

      // Bounds are signed and wide, so a band wider than the target goes negative.
      t_mv       = target;
      b_mv       = band;
      low_bound  = t_mv - b_mv;
      high_bound = t_mv + b_mv;
      level      = res.led_mv;

      res.duty   = duty_now;
      res.action = lbdr_pkg::ACT_HOLD;
      if (level < low_bound) begin
         res.action = lbdr_pkg::ACT_UP;
         if (duty_now < ceiling) begin
            res.duty = duty_now + 8'd1;
         end
      end else if (level > high_bound) begin
         res.action = lbdr_pkg::ACT_DOWN;
         if (duty_now > lbdr_pkg::DUTY_FLOOR) begin
            res.duty = duty_now - 8'd1;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      regulation_type want;
      regulation_type got;
      logic [5:0]     fill;

      if (reset) begin
         target_shadow  = lbdr_pkg::TARGET_RESET;
         band_shadow    = lbdr_pkg::BAND_RESET;
         ceiling_shadow = lbdr_pkg::CEILING_RESET;
         duty_shadow    = lbdr_pkg::DUTY_RESET;
         pending_results.delete();
      end else begin
         // Register writes update the shadow copy.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lbdr_pkg::REG_TARGET:  target_shadow  = csr_data;
               lbdr_pkg::REG_BAND:    band_shadow    = csr_data;
               lbdr_pkg::REG_CEILING: ceiling_shadow = csr_data[lbdr_pkg::DUTY_W-1:0];
               default: ;
            endcase
         end

         // Result beats are compared before new expectations are queued.
         if (rsp_tvalid && rsp_tready) begin
            got.duty   = rsp_tdata[7:0];
            got.led_mv = rsp_tdata[23:8];
            got.action = rsp_tdata[25:24];
            fill       = rsp_tdata[31:26];
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX) begin
                  $display("unexpected result beat: duty %0d led_mv %0d action %0d",
                           got.duty, got.led_mv, got.action);
               end
            end else begin
               want = pending_results.pop_front();
               checked++;
               if (got.duty != want.duty || got.led_mv != want.led_mv ||
                   got.action != want.action || fill != '0) begin
                  errors++;
                  if (errors <= REPORT_MAX) begin
                     $display("result %0d: expected duty %0d led_mv %0d action %0d fill 0",
                              checked, want.duty, want.led_mv, want.action);
                     $display("result %0d:      got duty %0d led_mv %0d action %0d fill %0d",
                              checked, got.duty, got.led_mv, got.action, fill);
                  end
               end
            end
         end

         // Each accepted sample pair yields exactly one result.
         if (req_tvalid && req_tready) begin
            want = regulate_pair(req_tdata[11:0], req_tdata[23:12], target_shadow,
                                 band_shadow, ceiling_shadow, duty_shadow);
            duty_shadow = want.duty;
            pending_results.push_back(want);
         end
      end

      mismatch_count  <= errors;
      outstanding     <= pending_results.size();
      results_checked <= checked;
   end

endmodule

[sim/tb_led_boost_deadband_regulator_unit.sv]
// Testbench top for the LED boost dead-band regulator: drives sample pairs and
// register settings, throttles the result side and gives the verdict.
// Depends on lbdr_pkg, led_boost_deadband_regulator_unit and lbdr_regulation_checker.
module tb_led_boost_deadband_regulator_unit;

   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 184;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 40;
   localparam int LIMIT       = 600000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   logic idle_enable   = 1'b1;
   logic stall_request = 1'b0;
   int   pairs_sent    = 0;
   int   cycle_count   = 0;
   int   mismatch_count;
   int   outstanding;
   int   results_checked;

   led_boost_deadband_regulator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lbdr_regulation_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit: ends a hung simulation.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("led_boost_deadband_regulator_unit: mismatch");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off that backs up the block.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall_request <= 1'b0;
         end else begin
            rsp_tready <= !idle_enable || ($urandom_range(99) >= 15);
         end
      end
   end

   // Offers one sample pair and holds it until the beat is taken.
   task automatic send_pair(input logic [11:0] ref_code, input logic [11:0] led_code);
      while (idle_enable && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {led_code, ref_code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pairs_sent++;
   endtask

   // Writes all three registers back to back; the ceiling carries junk above bit 7.
   task automatic write_settings(input logic [15:0] target, input logic [15:0] band,
                                 input logic [7:0] ceiling);
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         case (i)
            0: begin
               csr_index <= lbdr_pkg::REG_TARGET;
               csr_data  <= target;
            end
            1: begin
               csr_index <= lbdr_pkg::REG_BAND;
               csr_data  <= band;
            end
            default: begin
               csr_index <= lbdr_pkg::REG_CEILING;
               csr_data  <= {8'($urandom), ceiling};
            end
         endcase
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Waits until every predicted result has come back.
   task automatic drain_results();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      logic [11:0] ref_s;
      logic [11:0] led_s;
      logic [15:0] tgt;
      logic [15:0] bnd;
      logic [7:0]  ceil;
      int          pick;
      int          supply;
      int          level;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings: the first beat meets duty at its floor.
      send_pair(12'd0, 12'd4095);     // zero reference, saturated product
      send_pair(12'd0, 12'd0);
      send_pair(12'd1, 12'd1);        // quotient far above the 16-bit limit
      send_pair(12'd155, 12'd2000);   // just above the quotient limit
      send_pair(12'd156, 12'd100);    // just below it
      send_pair(12'd4095, 12'd4095);
      send_pair(12'd4095, 12'd0);
      send_pair(12'd1251, 12'd365);   // inside the dead band
      send_pair(12'hAAA, 12'h555);
      send_pair(12'h555, 12'hAAA);
      send_pair(12'd1251, 12'd320);   // close to the lower band edge
      send_pair(12'd1251, 12'd318);
      send_pair(12'd2048, 12'd600);
      req_tvalid <= 1'b0;
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               tgt = 16'd8000; bnd = 16'd0; ceil = 8'd255;
            end
            1: begin
               // Band wider than the target: never a step up.
               tgt = 16'd0; bnd = 16'd65535; ceil = 8'd1;
            end
            2: begin
               // Everything short of a saturated reading is below target: duty climbs to the top of its range.
               tgt = 16'd65535; bnd = 16'd0; ceil = 8'd255;
            end
            3: begin
               // Zero ceiling with duty far above it.
               tgt = 16'd40000; bnd = 16'd0; ceil = 8'd0;
            end
            4: begin
               // Upper bound beyond 16 bits.
               tgt = 16'd65535; bnd = 16'd65535; ceil = 8'd128;
            end
            5: begin
               tgt = 16'd0; bnd = 16'd0; ceil = 8'd20;
            end
            default: begin
               tgt  = 16'($urandom_range(65535));
               bnd  = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                               : 16'($urandom_range(2500));
               ceil = 8'($urandom_range(255));
            end
         endcase
         // One whole phase runs with no idling on either side.
         idle_enable <= (p != 2);
         write_settings(tgt, bnd, ceil);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 6 && n == 40) begin
               stall_request <= 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 65) begin
               // Readings near the operating point, so the LED voltage hovers
               // around the band edges.
               ref_s  = 12'($urandom_range(1700, 900));
               supply = 10215000 / int'(ref_s);
               if (supply > 65535) begin
                  supply = 65535;
               end
               level = (int'(tgt) * 4096) / (supply * 11);
               level = level + int'($urandom_range(60)) - 30;
               if (level < 0) begin
                  level = 0;
               end else if (level > 4095) begin
                  level = 4095;
               end
               led_s = 12'(level);
            end else if (pick < 90) begin
               ref_s = 12'($urandom_range(4095));
               led_s = 12'($urandom_range(4095));
            end else begin
               case ($urandom_range(4))
                  0:       ref_s = 12'd0;
                  1:       ref_s = 12'd1;
                  2:       ref_s = 12'd155;
                  3:       ref_s = 12'd156;
                  default: ref_s = 12'd4095;
               endcase
               case ($urandom_range(2))
                  0:       led_s = 12'd0;
                  1:       led_s = 12'd4095;
                  default: led_s = 12'($urandom_range(4095));
               endcase
            end
            send_pair(ref_s, led_s);
         end
         req_tvalid <= 1'b0;
         drain_results();
      end

      repeat (SETTLE) @(posedge clock);

      $display("sent %0d sample pairs under %0d register settings, with saturating,",
               pairs_sent, PHASES + 1);
      $display("zero-reference and band-edge readings; %0d results compared",
               results_checked);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("led_boost_deadband_regulator_unit: match");
      end else begin
         $display("led_boost_deadband_regulator_unit: mismatch");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/lbdr_pkg.sv
sv/lbdr_divider.sv
sv/lbdr_scale.sv
sv/led_boost_deadband_regulator_unit.sv
sim/lbdr_regulation_checker.sv
sim/tb_led_boost_deadband_regulator_unit.sv
